@@ hw/rtl/sll_pkg.sv @@
// Shared types and codes for the static linked list engine.
// No dependencies; imported by sll_cell and static_linked_list_engine_core.
`timescale 1ns / 1ps

package sll_pkg;

    localparam int OP_W     = 2;
    localparam int POS_W    = 3;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 3;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Cell chain commands
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_HOLD   = 2'd0;
    localparam t_cmd CMD_INSERT = 2'd1;
    localparam t_cmd CMD_DELETE = 2'd2;
    localparam t_cmd CMD_ROTATE = 2'd3;

    typedef struct packed {
        t_cmd             cmd;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

@@ hw/rtl/sll_cell.sv @@
// One element cell of the list chain: holds one data word by list position.
// Depends on sll_pkg for the command codes and the control struct.
`timescale 1ns / 1ps

module sll_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  sll_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_new,
    input  logic [DATA_WIDTH-1:0] i_from_left,
    input  logic [DATA_WIDTH-1:0] i_from_right,
    output logic [DATA_WIDTH-1:0] o_data
);
    import sll_pkg::*;

    localparam int IW = (INDEX > 0) ? $clog2(INDEX + 1) : 1;
    localparam int CW = (IW > POS_W) ? IW : POS_W;
    localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [CW-1:0]         pos_ext;

    assign pos_ext = CW'(i_ctl.pos);

    always_comb begin
        n_data = r_data;
        case (i_ctl.cmd)
            CMD_HOLD: n_data = r_data;
            CMD_INSERT: begin
                // open a gap at the position, push later elements right
                if (MY_IDX == pos_ext) begin
                    n_data = i_new;
                end else if (MY_IDX > pos_ext) begin
                    n_data = i_from_left;
                end
            end
            CMD_DELETE: begin
                // close the gap, pull later elements left
                if (MY_IDX >= pos_ext) begin
                    n_data = i_from_right;
                end
            end
            CMD_ROTATE: n_data = i_from_right;
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ hw/rtl/static_linked_list_engine_core.sv @@
// Top level of the static linked list engine: request control and cell chain.
// Depends on sll_pkg and sll_cell.
`timescale 1ns / 1ps

// Channel   | Direction | Signals                                  | Handshake
// ----------+-----------+------------------------------------------+--------------------------
// request   | in        | i_op, i_position, i_value                | taken when start && !busy
// result    | out       | o_status, o_found_position, o_length     | o_valid, one cycle, no stall
//
// Insert, delete and an unused opcode pass through S_EXEC, and their result is
// registered into o_valid and the result outputs; find runs S_SCAN for one full
// rotation of the NODES-1 cell ring past the compare point at cell 0. One request
// is in flight at a time. Reset (i_rst_n low at a clock edge) empties the list and
// drops any request in flight. The result receiver cannot stall; busy is the only
// back pressure on the request side.
//
// The list is kept by position rather than by explicit links: cell k holds the
// k-th element, so the slot/link bookkeeping of a node array collapses into
// shifting the chain and a length counter. The results are the same, since slot
// numbers never reach the outputs.

module static_linked_list_engine_core #(
    parameter int NODES      = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [sll_pkg::OP_W-1:0]     i_op,
    input  logic [sll_pkg::POS_W-1:0]    i_position,
    input  logic signed [31:0]           i_value,
    output logic                         o_valid,
    output logic [sll_pkg::STATUS_W-1:0] o_status,
    output logic [sll_pkg::POS_W-1:0]    o_found_position,
    output logic [sll_pkg::LEN_W-1:0]    o_length
);
    import sll_pkg::*;

    localparam int CELLS = NODES - 1;
    localparam int CW    = $clog2(NODES);
    localparam int PW    = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(NODES - 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(NODES - 2);

    // Sequencer state codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    // Control registers
    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_found, n_found;
    logic                  r_o_valid, n_o_valid;

    // Payload registers
    logic [OP_W-1:0]       r_op, n_op;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [CW-1:0]         r_step, n_step;
    logic [POS_W-1:0]      r_found_idx, n_found_idx;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [POS_W-1:0]      r_found_pos, n_found_pos;

    logic [63:0]           value_sx;
    logic                  accept;
    logic                  hit;
    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;
    t_cell_ctl             cell_ctl;
    logic [DATA_WIDTH-1:0] cell_data [CELLS];

    // Sign-extend the request value, then keep its low DATA_WIDTH bits
    assign value_sx = {{32{i_value[31]}}, i_value};
    assign accept   = start && !busy;
    assign pos_ext  = PW'(r_pos);
    assign cnt_ext  = PW'(r_count);

    // Element at the compare point during a scan; only live elements count
    assign hit = (cell_data[0] == r_value) && (r_step < r_count) && !r_found;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_found      = r_found;
        n_o_valid    = 1'b0;
        n_op         = r_op;
        n_pos        = r_pos;
        n_value      = r_value;
        n_step       = r_step;
        n_found_idx  = r_found_idx;
        n_status     = r_status;
        n_found_pos  = r_found_pos;
        cell_ctl.cmd = CMD_HOLD;
        cell_ctl.pos = r_pos;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // latch the request; find goes straight to the ring scan
                    n_op        = i_op;
                    n_pos       = i_position;
                    n_value     = value_sx[DATA_WIDTH-1:0];
                    n_step      = '0;
                    n_found     = 1'b0;
                    n_found_idx = '0;
                    n_state     = (i_op == OP_FIND) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                n_status    = ST_OK;
                n_found_pos = '0;
                case (r_op)
                    OP_INSERT: begin
                        // position check comes before the full check
                        if (pos_ext > cnt_ext) begin
                            n_status = ST_BAD_POS;
                        end else if (r_count == MAX_COUNT) begin
                            n_status = ST_FULL;
                        end else begin
                            cell_ctl.cmd = CMD_INSERT;
                            n_count      = CW'(r_count + 1'b1);
                        end
                    end
                    OP_DELETE: begin
                        if (pos_ext >= cnt_ext) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            cell_ctl.cmd = CMD_DELETE;
                            n_count      = CW'(r_count - 1'b1);
                        end
                    end
                    default: n_status = ST_OK;
                endcase
                n_o_valid = 1'b1;
                n_state   = S_IDLE;
            end
            S_SCAN: begin
                // rotate the ring one cell left; element r_step sits at cell 0
                cell_ctl.cmd = CMD_ROTATE;
                n_step       = CW'(r_step + 1'b1);
                if (hit) begin
                    n_found     = 1'b1;
                    n_found_idx = POS_W'(r_step);
                end
                if (r_step == LAST_STEP) begin
                    // a full turn restores the original order
                    n_status    = (r_found || hit) ? ST_OK : ST_NOT_FOUND;
                    n_found_pos = hit ? POS_W'(r_step) : r_found_idx;
                    n_o_valid   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_found   <= n_found;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_pos       <= n_pos;
        r_value     <= n_value;
        r_step      <= n_step;
        r_found_idx <= n_found_idx;
        r_status    <= n_status;
        r_found_pos <= n_found_pos;
    end

    // Cell chain closed into a ring: right of the last cell is cell 0
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        localparam int LEFT  = (g == 0) ? CELLS - 1 : g - 1;
        localparam int RIGHT = (g == CELLS - 1) ? 0 : g + 1;

        sll_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_new        (r_value),
            .i_from_left  (cell_data[LEFT]),
            .i_from_right (cell_data[RIGHT]),
            .o_data       (cell_data[g])
        );
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found_pos;
    assign o_length         = LEN_W'(r_count);

    // Results appear only once the sequencer is back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // A taken request always occupies the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but sequencer not busy");

    // Length moves only together with a delivered result
    a_count_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> o_valid)
        else $error("length changed without a result");

    // A full report means the chain is at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (r_count == MAX_COUNT))
        else $error("full status with free capacity");

endmodule
